FILE: hdl/lphm_pkg.sv
// Shared types and constants for the linear-probe hash map core.
package lphm_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 10;
    localparam int STATUS_W = 2;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

FILE: hdl/lphm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lphm_hash.sv
// Iterative 64-bit FNV-1a hash unit, one key byte per cycle.
module lphm_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lphm_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [lphm_pkg::KEY_W-1:0] hash
);

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam int          ROUNDS     = 8;

    logic [63:0] h_reg, h_next;
    logic [63:0] k_reg, k_next;
    logic [2:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // Xor in one byte, then multiply by the FNV prime 2^40 + 0x1b3 as shifts and adds.
    function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] t;
        t = h ^ {56'd0, b};
        return t + (t << 1) + (t << 4) + (t << 5) + (t << 7) + (t << 8) + (t << 40);
    endfunction

    always_comb begin
        h_next     = h_reg;
        k_next     = k_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            h_next     = FNV_OFFSET;
            k_next     = key;
            round_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            h_next     = fnv_round(h_reg, k_reg[7:0]);
            k_next     = k_reg >> 8;
            round_next = round_reg + 3'(1);
            if (round_reg == 3'(ROUNDS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
        h_reg <= h_next;
        k_reg <= k_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

FILE: hdl/linear_probe_hash_map_core.sv
// Top level of the linear-probe hash map: request sequencing, probing and result register.
//
//  channel  dir  tdata (low bit up)               tuser
//  s_       in   key[63:0], value[95:64]          operation
//  m_       out  value_out[31:0], entry_total[41:32], pad  status
//
//  An item passes through accept, hashing, issue of the home read, one cycle per probed
//  slot through the single table read port, and a result step that waits while the
//  held result is not taken. A set with a zero value skips hashing for the result step.
//  After reset a clearing pass writes every table slot empty with s_tready low.
//  The result register holds an item while the next one is accepted and worked on.
module linear_probe_hash_map_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key, value
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // value_out, entry_total, zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] HALF = IDX_W'(TABLE_DEPTH / 2);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                              op_reg, op_next;
    logic [lphm_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [lphm_pkg::VALUE_W-1:0]      val_reg, val_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [IDX_W-1:0]                  probe_reg, probe_next;
    logic [IDX_W-1:0]                  count_reg, count_next;
    logic [lphm_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [lphm_pkg::VALUE_W-1:0]      res_value_reg, res_value_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [lphm_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [lphm_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [lphm_pkg::ENTRY_W-1:0]      out_total_reg, out_total_next;

    logic                              hash_start;
    logic                              hash_done;
    logic [lphm_pkg::KEY_W-1:0]        hash_val;

    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    lphm_pkg::slot_t                   wr_slot;
    logic [IDX_W-1:0]                  rd_addr;
    lphm_pkg::slot_t                   rd_slot;

    logic                              hit;
    logic                              empty;
    logic                              last_probe;
    logic                              full;

    lphm_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_next),
        .done    (hash_done),
        .hash    (hash_val)
    );

    lphm_ram #(
        .WIDTH ($bits(lphm_pkg::slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_addr (rd_addr),
        .rd_data (rd_slot)
    );

    assign hit        = rd_slot.used && (rd_slot.key == key_reg);
    assign empty      = !rd_slot.used;
    assign last_probe = (probe_reg == '1);
    assign full       = (count_reg >= HALF);
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        case (state_reg)
            ST_HASH:  rd_addr = hash_val[IDX_W-1:0];
            ST_CHECK: rd_addr = idx_reg + IDX_W'(1);
            default:  rd_addr = idx_reg;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_total_next  = out_total_reg;
        hash_start      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_slot.used    = 1'b1;
        wr_slot.key     = key_reg;
        wr_slot.value   = val_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_slot.used = 1'b0;
                idx_next     = idx_reg + IDX_W'(1);
                if (idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tuser;
                    key_next = s_tdata[63:0];
                    val_next = s_tdata[95:64];
                    if (s_tuser == lphm_pkg::OP_SET && s_tdata[95:64] == '0) begin
                        res_status_next = lphm_pkg::ST_INVALID;
                        res_value_next  = '0;
                        state_next      = ST_RESP;
                    end else begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    idx_next   = hash_val[IDX_W-1:0];
                    probe_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_value_next = '0;
                if (hit) begin
                    res_status_next = lphm_pkg::ST_OK;
                    if (op_reg == lphm_pkg::OP_SET) begin
                        wr_en = 1'b1;
                    end else begin
                        res_value_next = rd_slot.value;
                    end
                    state_next = ST_RESP;
                end else if (empty) begin
                    if (op_reg == lphm_pkg::OP_GET) begin
                        res_status_next = lphm_pkg::ST_NOT_FOUND;
                    end else if (full) begin
                        res_status_next = lphm_pkg::ST_FULL;
                    end else begin
                        res_status_next = lphm_pkg::ST_OK;
                        wr_en           = 1'b1;
                        count_next      = count_reg + IDX_W'(1);
                    end
                    state_next = ST_RESP;
                end else if (last_probe) begin
                    res_status_next = (op_reg == lphm_pkg::OP_GET) ?
                                      lphm_pkg::ST_NOT_FOUND : lphm_pkg::ST_FULL;
                    state_next = ST_RESP;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    probe_next = probe_reg + IDX_W'(1);
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_total_next  = lphm_pkg::ENTRY_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        probe_reg      <= probe_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_total_reg  <= out_total_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, out_total_reg, out_value_reg};

endmodule

FILE: hdl/lphm_checker.sv
// Port-level assertions for the linear-probe hash map core, bound to the top level.
module lphm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is at work");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != lphm_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero value on a failed request");

endmodule

bind linear_probe_hash_map_core lphm_checker u_lphm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/testbench.sv
// Self-checking testbench for the linear-probe hash map core: predicted set/get responses.
module testbench;

    localparam int TABLE_DEPTH = 1024;
    localparam int HALF_DEPTH  = TABLE_DEPTH / 2;
    localparam logic [lphm_pkg::KEY_W-1:0] IDX_MASK  = lphm_pkg::KEY_W'(TABLE_DEPTH - 1);
    localparam logic [lphm_pkg::KEY_W-1:0] HASH_SEED = 64'hcbf29ce484222325;
    localparam logic [lphm_pkg::KEY_W-1:0] FNV_MUL   = 64'h00000100000001b3;
    localparam int POOL_SIZE   = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 1200;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [lphm_pkg::STATUS_W-1:0] status;
        logic [lphm_pkg::VALUE_W-1:0]  value_out;
        logic [lphm_pkg::ENTRY_W-1:0]  entry_total;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;               // key[63:0], value[95:64]
    logic        s_tuser = lphm_pkg::OP_GET; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // value_out[31:0], entry_total[41:32], zero pad[47:42]
    logic [1:0]  m_tuser;          // status

    linear_probe_hash_map_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    bit                           occupied[TABLE_DEPTH];
    logic [lphm_pkg::KEY_W-1:0]   stored_key[TABLE_DEPTH];
    logic [lphm_pkg::VALUE_W-1:0] stored_value[TABLE_DEPTH];
    int                           stored_entries = 0;

    response_t                    pending_responses[$];
    logic [lphm_pkg::KEY_W-1:0]   key_pool[POOL_SIZE];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [lphm_pkg::KEY_W-1:0] key_hash(
            input logic [lphm_pkg::KEY_W-1:0] key);
        logic [lphm_pkg::KEY_W-1:0] h;
        h = HASH_SEED;
        for (int b = 0; b < 8; b++) begin
            h = h ^ {56'd0, key[8*b +: 8]};
            h = h * FNV_MUL;
        end
        return h;
    endfunction

    function automatic int home_slot(input logic [lphm_pkg::KEY_W-1:0] key);
        return int'(key_hash(key) & IDX_MASK);
    endfunction

    function automatic logic [lphm_pkg::KEY_W-1:0] key_homed_at(input int slot);
        logic [lphm_pkg::KEY_W-1:0] k;
        k = {$urandom, $urandom};
        while (home_slot(k) != slot) k = {$urandom, $urandom};
        return k;
    endfunction

    function automatic response_t apply_request(input logic op,
                                                input logic [lphm_pkg::KEY_W-1:0] key,
                                                input logic [lphm_pkg::VALUE_W-1:0] value);
        response_t r;
        int slot;
        bit hit;
        bit free_found;
        r.status = lphm_pkg::ST_OK;
        r.value_out = '0;
        if (op == lphm_pkg::OP_SET && value == '0) begin
            r.status = lphm_pkg::ST_INVALID;
        end else begin
            slot = home_slot(key);
            hit = 1'b0;
            free_found = 1'b0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                if (!occupied[slot]) begin
                    free_found = 1'b1;
                    break;
                end
                if (stored_key[slot] == key) begin
                    hit = 1'b1;
                    break;
                end
                slot = (slot + 1) % TABLE_DEPTH;
            end
            if (!hit && !free_found) slot = 0;
            if (op == lphm_pkg::OP_GET) begin
                if (hit) r.value_out = stored_value[slot];
                else r.status = lphm_pkg::ST_NOT_FOUND;
            end else if (hit) begin
                stored_value[slot] = value;
            end else if (stored_entries >= HALF_DEPTH || !free_found) begin
                r.status = lphm_pkg::ST_FULL;
            end else begin
                occupied[slot] = 1'b1;
                stored_key[slot] = key;
                stored_value[slot] = value;
                stored_entries++;
            end
        end
        r.entry_total = lphm_pkg::ENTRY_W'(stored_entries);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(input logic op, input logic [lphm_pkg::KEY_W-1:0] key,
                                input logic [lphm_pkg::VALUE_W-1:0] value);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_responses.push_back(apply_request(op, key, value));
    endtask

    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_item(input int fresh_set_pct);
        logic op;
        logic [lphm_pkg::KEY_W-1:0] k;
        logic [lphm_pkg::VALUE_W-1:0] v;
        op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 70) begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            k = {$urandom, $urandom};
            if ($urandom_range(0, 99) >= fresh_set_pct) op = lphm_pkg::OP_GET;
        end
        v = ($urandom_range(0, 99) < 5) ? '0 : lphm_pkg::VALUE_W'($urandom);
        send_request(op, k, v);
    endtask

    always @(posedge aclk) begin : hold_counter
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : response_check
        response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with nothing outstanding");
            end else begin
                want = pending_responses.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
                if (m_tdata[31:0] !== want.value_out)
                    report_mismatch($sformatf("value_out %h, want %h",
                                              m_tdata[31:0], want.value_out));
                if (m_tdata[41:32] !== want.entry_total)
                    report_mismatch($sformatf("entry_total %0d, want %0d",
                                              m_tdata[41:32], want.entry_total));
                if (m_tdata[47:42] !== 6'd0)
                    report_mismatch($sformatf("pad bits %b not zero", m_tdata[47:42]));
            end
        end
        if (hold_left > 0) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic test_directed();
        logic [lphm_pkg::KEY_W-1:0] wrap_key[4];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(lphm_pkg::OP_GET, '0, '0);
        send_request(lphm_pkg::OP_SET, '0, '0);
        send_request(lphm_pkg::OP_SET, '0, 32'hffffffff);
        send_request(lphm_pkg::OP_SET, '1, 32'h00000001);
        send_request(lphm_pkg::OP_GET, '0, 32'h12345678);
        send_request(lphm_pkg::OP_GET, '1, '0);
        send_request(lphm_pkg::OP_SET, '0, 32'h5a5a5a5a);
        send_request(lphm_pkg::OP_GET, '0, '1);
        send_request(lphm_pkg::OP_SET, '1, '0);
        send_request(lphm_pkg::OP_GET, '1, '0);
        send_request(lphm_pkg::OP_GET, 64'h8000000000000000, '0);
        // fill the top slot and wrap the probe around to slot zero
        for (int i = 0; i < 4; i++) wrap_key[i] = key_homed_at(TABLE_DEPTH - 1);
        for (int i = 0; i < 3; i++)
            send_request(lphm_pkg::OP_SET, wrap_key[i], lphm_pkg::VALUE_W'($urandom));
        send_request(lphm_pkg::OP_GET, wrap_key[2], '0);
        send_request(lphm_pkg::OP_GET, wrap_key[3], '0);
        send_request(lphm_pkg::OP_SET, wrap_key[1], 32'h80000000);
        send_request(lphm_pkg::OP_GET, wrap_key[1], '0);
        send_request(lphm_pkg::OP_GET, wrap_key[0], '0);
        wait_for_responses();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) send_random_item(10);
        wait_for_responses();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 40; i++) send_random_item(10);
        wait_for_responses();
    endtask

    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 18;
        for (int i = 0; i < 20; i++) send_random_item(10);
        wait_for_responses();
        for (int i = 0; i < 20; i++) send_random_item(10);
        wait_for_responses();
    endtask

    task automatic test_fill_table();
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        while (stored_entries < HALF_DEPTH)
            send_request(lphm_pkg::OP_SET, {$urandom, $urandom},
                         lphm_pkg::VALUE_W'($urandom_range(1, 32'hffffffff)));
        for (int i = 0; i < 8; i++)
            send_request(lphm_pkg::OP_SET, {$urandom, $urandom},
                         lphm_pkg::VALUE_W'($urandom_range(1, 32'hffffffff)));
        for (int i = 0; i < 8; i++)
            send_request(lphm_pkg::OP_SET, key_pool[i],
                         lphm_pkg::VALUE_W'($urandom_range(1, 32'hffffffff)));
        for (int i = 0; i < 8; i++) send_request(lphm_pkg::OP_GET, key_pool[i], '0);
        wait_for_responses();
    endtask

    task automatic test_full_random(input int count);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) send_idle_pct = 72;
            if (i == 2 * count / 3) recv_stall_pct = 72;
            send_random_item(100);
        end
        wait_for_responses();
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(400, 0, 0);
        test_random(400, 72, 0);
        test_random(400, 0, 72);
        test_random(400, 18, 18);
        test_backpressure();
        test_sender_pause();
        test_fill_table();
        test_full_random(300);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d responses outstanding", pending_responses.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
